### rtl/llsn_pkg.sv
// llsn_pkg: shared types, fixed-point constants and reciprocal table for the
// log-likelihood softmax normalizer. No dependencies.
package llsn_pkg;

	localparam int DEF_MAX_ITEMS = 64;
	localparam int CUT_W = 22;

	localparam logic [21:0] LN_1E16_Q = 22'd2414435;
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	localparam logic [15:0] LN2_Q16 = 16'd45426;
	localparam logic [16:0] LN2_RECIP = 17'd94548;
	localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
	localparam logic [3:0] TERMS = 4'd12;

	typedef struct packed {
		logic signed [31:0] log_likelihood;
		logic last_item;
	} llsn_in_t;

	typedef struct packed {
		logic [16:0] probability;
		logic [5:0] item_index;
		logic last_result;
		logic truncated;
	} llsn_out_t;

	typedef struct packed {
		logic load;
		logic ln_go;
		logic rd;
		logic cmp;
		logic exp_go;
		logic acc;
		logic div_go;
		logic emit;
		logic idx_clr;
	} llsn_cmd_t;

	typedef struct packed {
		logic ln_done;
		logic exp_done;
		logic div_done;
		logic keep;
		logic idx_last;
	} llsn_sts_t;

	// floor(2^32 / k), never more than one below the exact quotient
	function automatic logic [32:0] recip_k(input logic [3:0] k);
		logic [32:0] r;
		case (k)
			4'd1: r = 33'h1_0000_0000;
			4'd2: r = 33'd2147483648;
			4'd3: r = 33'd1431655765;
			4'd4: r = 33'd1073741824;
			4'd5: r = 33'd858993459;
			4'd6: r = 33'd715827882;
			4'd7: r = 33'd613566756;
			4'd8: r = 33'd536870912;
			4'd9: r = 33'd477218588;
			4'd10: r = 33'd429496729;
			4'd11: r = 33'd390451572;
			4'd12: r = 33'd357913941;
			default: r = 33'd0;
		endcase
		return r;
	endfunction

endpackage

### rtl/llsn_ram.sv
// llsn_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module llsn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/llsn_exp.sv
// llsn_exp: iterative exp(-t) unit, unsigned Q6.16 in, unsigned Q1.31 out.
// Range reduction by ln2, then a Taylor series up to the 12th power. Uses llsn_pkg.
module llsn_exp import llsn_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic go,
	input logic [CUT_W-1:0] t,
	output logic done,
	output logic [31:0] value
);

	localparam logic [2:0] X_IDLE = 3'd0;
	localparam logic [2:0] X_Q1 = 3'd1;
	localparam logic [2:0] X_Q2 = 3'd2;
	localparam logic [2:0] X_Q3 = 3'd3;
	localparam logic [2:0] X_M1 = 3'd4;
	localparam logic [2:0] X_M2 = 3'd5;
	localparam logic [2:0] X_M3 = 3'd6;
	localparam logic [2:0] X_FIN = 3'd7;

	logic [2:0] state_q;
	logic [CUT_W-1:0] t_q;
	logic [38:0] prod_q;
	logic [22:0] qm_q;
	logic [6:0] q_q;
	logic [30:0] r31_q;
	logic [31:0] term_q;
	logic signed [33:0] sum_q;
	logic [3:0] k_q;
	logic [31:0] x_q;
	logic [31:0] qk_q;
	logic [31:0] res_q;
	logic done_q;

	logic [22:0] r_raw;
	logic [22:0] r_fix;
	logic [35:0] rem;
	logic [31:0] term_new;
	logic [31:0] clamped;

	always_comb begin
		r_raw = {1'b0, t_q} - qm_q;
		r_fix = (r_raw >= 23'(LN2_Q16)) ? r_raw - 23'(LN2_Q16) : r_raw;
		rem = 36'(x_q) - 36'(qk_q) * 36'(k_q);
		term_new = (rem >= 36'(k_q)) ? qk_q + 32'd1 : qk_q;
		if (sum_q < 0) begin
			clamped = 32'd0;
		end else if (sum_q > 34'sd2147483648) begin
			clamped = ONE_Q31;
		end else begin
			clamped = sum_q[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= X_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				X_IDLE: begin
					if (go) begin
						t_q <= t;
						state_q <= X_Q1;
					end
				end
				X_Q1: begin
					prod_q <= 39'(t_q) * 39'(LN2_RECIP);
					state_q <= X_Q2;
				end
				X_Q2: begin
					q_q <= prod_q[38:32];
					qm_q <= 23'(prod_q[38:32]) * 23'(LN2_Q16);
					state_q <= X_Q3;
				end
				X_Q3: begin
					if (r_raw >= 23'(LN2_Q16)) begin
						q_q <= q_q + 7'd1;
					end
					r31_q <= {r_fix[15:0], 15'd0};
					term_q <= ONE_Q31;
					sum_q <= 34'sd2147483648;
					k_q <= 4'd1;
					state_q <= X_M1;
				end
				X_M1: begin
					x_q <= 32'((64'(term_q) * 64'(r31_q)) >> 31);
					state_q <= X_M2;
				end
				X_M2: begin
					qk_q <= 32'((65'(x_q) * 65'(recip_k(k_q))) >> 32);
					state_q <= X_M3;
				end
				X_M3: begin
					term_q <= term_new;
					if (k_q[0]) begin
						sum_q <= sum_q - $signed({2'b00, term_new});
					end else begin
						sum_q <= sum_q + $signed({2'b00, term_new});
					end
					if (k_q == TERMS) begin
						state_q <= X_FIN;
					end else begin
						k_q <= k_q + 4'd1;
						state_q <= X_M1;
					end
				end
				X_FIN: begin
					res_q <= (q_q >= 7'd32) ? 32'd0 : clamped >> q_q[4:0];
					done_q <= 1'b1;
					state_q <= X_IDLE;
				end
				default: begin
					state_q <= X_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign value = res_q;

endmodule

### rtl/llsn_dp.sv
// llsn_dp: datapath with value RAM, running max, cutoff (ln) unit, exp unit,
// exp sum and restoring divider. Uses llsn_pkg, llsn_ram, llsn_exp.
module llsn_dp import llsn_pkg::*; #(
	parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
	input logic clk,
	input logic arst_n,
	input llsn_in_t item,
	input llsn_cmd_t cmd,
	output llsn_sts_t sts,
	output logic strobe,
	output llsn_out_t result
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);

	logic [CW-1:0] count_q;
	logic signed [31:0] max_q;
	logic [37:0] total_q;
	logic ovf_q;
	logic [CW-1:0] idx_q;
	logic keep_q;
	logic [CUT_W-1:0] t_q;
	logic [31:0] rdata;

	logic room;
	logic we;
	logic idx_last;
	logic signed [32:0] diff;
	logic exp_done;
	logic [31:0] exp_val;
	logic [31:0] e_use;

	// cutoff unit
	logic ln_busy_q;
	logic [4:0] ln_cnt_q;
	logic [30:0] ln_y_q;
	logic [15:0] ln_frac_q;
	logic [2:0] ln_k_q;
	logic ln_done_q;
	logic [CUT_W-1:0] cut_q;
	logic [2:0] k_init;
	logic [61:0] ln_sq;
	logic [31:0] ln_ys;
	logic [50:0] ln_prod;

	// divider
	logic div_busy_q;
	logic [4:0] div_cnt_q;
	logic [37:0] rem_q;
	logic [16:0] nb_q;
	logic [16:0] quo_q;
	logic div_done_q;
	logic [38:0] r2;

	logic [16:0] prob;
	llsn_out_t result_q;
	logic strobe_q;

	assign room = count_q < CW'(MAX_ITEMS);
	assign we = cmd.load && room;
	assign idx_last = (idx_q + CW'(1)) == count_q;
	assign diff = {max_q[31], max_q} - {rdata[31], rdata};
	assign e_use = keep_q ? exp_val : 32'd0;

	llsn_ram #(
		.WIDTH(32),
		.DEPTH(MAX_ITEMS)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(count_q[AW-1:0]),
		.wdata(item.log_likelihood),
		.re(cmd.rd),
		.raddr(idx_q[AW-1:0]),
		.rdata(rdata)
	);

	llsn_exp u_exp (
		.clk(clk),
		.arst_n(arst_n),
		.go(cmd.exp_go),
		.t(t_q),
		.done(exp_done),
		.value(exp_val)
	);

	always_comb begin
		k_init = 3'd0;
		for (int b = 0; b < CW; b++) begin
			if (count_q[b]) begin
				k_init = 3'(b);
			end
		end
		ln_sq = 62'(ln_y_q) * 62'(ln_y_q);
		ln_ys = 32'(ln_sq >> 30);
		ln_prod = 51'({ln_k_q, ln_frac_q}) * 51'(LN2_Q32);
		r2 = {rem_q, nb_q[16]};
		prob = (total_q == 38'd0) ? 17'd0 : quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			max_q <= 32'sh8000_0000;
			total_q <= '0;
			ovf_q <= 1'b0;
			idx_q <= '0;
			ln_busy_q <= 1'b0;
			ln_done_q <= 1'b0;
			div_busy_q <= 1'b0;
			div_done_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			ln_done_q <= 1'b0;
			div_done_q <= 1'b0;
			strobe_q <= cmd.emit;

			if (cmd.load) begin
				if (room) begin
					count_q <= count_q + CW'(1);
					if (item.log_likelihood > max_q) begin
						max_q <= item.log_likelihood;
					end
				end else begin
					ovf_q <= 1'b1;
				end
			end

			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.acc || cmd.emit) begin
				idx_q <= idx_q + CW'(1);
			end

			if (cmd.acc) begin
				total_q <= total_q + 38'(e_use);
			end

			if (cmd.ln_go) begin
				ln_busy_q <= 1'b1;
				ln_cnt_q <= 5'd16;
				ln_k_q <= k_init;
				ln_y_q <= 31'(({count_q, 30'd0}) >> k_init);
				ln_frac_q <= '0;
			end else if (ln_busy_q) begin
				if (ln_cnt_q != 5'd0) begin
					ln_cnt_q <= ln_cnt_q - 5'd1;
					ln_y_q <= ln_ys[31] ? ln_ys[31:1] : ln_ys[30:0];
					ln_frac_q <= {ln_frac_q[14:0], ln_ys[31]};
				end else begin
					cut_q <= LN_1E16_Q + CUT_W'(ln_prod >> 32);
					ln_busy_q <= 1'b0;
					ln_done_q <= 1'b1;
				end
			end

			if (cmd.div_go) begin
				div_busy_q <= 1'b1;
				div_cnt_q <= 5'd17;
				rem_q <= 38'(e_use[31:1]);
				nb_q <= {e_use[0], 16'd0};
				quo_q <= '0;
			end else if (div_busy_q) begin
				if (r2 >= {1'b0, total_q}) begin
					rem_q <= 38'(r2 - {1'b0, total_q});
					quo_q <= {quo_q[15:0], 1'b1};
				end else begin
					rem_q <= r2[37:0];
					quo_q <= {quo_q[15:0], 1'b0};
				end
				nb_q <= {nb_q[15:0], 1'b0};
				div_cnt_q <= div_cnt_q - 5'd1;
				if (div_cnt_q == 5'd1) begin
					div_busy_q <= 1'b0;
					div_done_q <= 1'b1;
				end
			end

			if (cmd.emit && idx_last) begin
				count_q <= '0;
				max_q <= 32'sh8000_0000;
				total_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			keep_q <= diff < $signed({11'd0, cut_q});
			t_q <= diff[CUT_W-1:0];
		end
		if (cmd.emit) begin
			result_q.probability <= prob;
			result_q.item_index <= 6'(idx_q);
			result_q.last_result <= idx_last;
			result_q.truncated <= ovf_q;
		end
	end

	assign sts.ln_done = ln_done_q;
	assign sts.exp_done = exp_done;
	assign sts.div_done = div_done_q;
	assign sts.keep = keep_q;
	assign sts.idx_last = idx_last;
	assign strobe = strobe_q;
	assign result = result_q;

endmodule

### rtl/llsn_ctrl.sv
// llsn_ctrl: controller state machine sequencing load, cutoff, sum pass and
// output pass. Uses llsn_pkg.
module llsn_ctrl import llsn_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic last_item,
	input llsn_sts_t sts,
	output llsn_cmd_t cmd,
	output logic busy
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LN = 4'd1;
	localparam logic [3:0] S_LNW = 4'd2;
	localparam logic [3:0] S_RD = 4'd3;
	localparam logic [3:0] S_CMP = 4'd4;
	localparam logic [3:0] S_EXP = 4'd5;
	localparam logic [3:0] S_EXPW = 4'd6;
	localparam logic [3:0] S_USE = 4'd7;
	localparam logic [3:0] S_DIVW = 4'd8;
	localparam logic [3:0] S_EMIT = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic pass_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (last_item) begin
						state_d = S_LN;
					end
				end
			end
			S_LN: begin
				cmd.ln_go = 1'b1;
				cmd.idx_clr = 1'b1;
				state_d = S_LNW;
			end
			S_LNW: begin
				if (sts.ln_done) begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				cmd.rd = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				cmd.cmp = 1'b1;
				state_d = S_EXP;
			end
			S_EXP: begin
				if (sts.keep) begin
					cmd.exp_go = 1'b1;
					state_d = S_EXPW;
				end else begin
					state_d = S_USE;
				end
			end
			S_EXPW: begin
				if (sts.exp_done) begin
					state_d = S_USE;
				end
			end
			S_USE: begin
				if (!pass_q) begin
					cmd.acc = 1'b1;
					cmd.idx_clr = sts.idx_last;
					state_d = S_RD;
				end else begin
					cmd.div_go = 1'b1;
					state_d = S_DIVW;
				end
			end
			S_DIVW: begin
				if (sts.div_done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				state_d = sts.idx_last ? S_IDLE : S_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_USE && !pass_q && sts.idx_last) begin
				pass_q <= 1'b1;
			end else if (state_q == S_EMIT && sts.idx_last) begin
				pass_q <= 1'b0;
			end
		end
	end

	assign busy = state_q != S_IDLE;

endmodule

### rtl/log_likelihood_softmax_normalizer.sv
// log_likelihood_softmax_normalizer: top level, controller plus datapath.
// Uses llsn_pkg, llsn_ctrl, llsn_dp.
//
// An item transfers when start is high and busy is low. Items load at one per
// cycle; the item with last_item set closes the vector and raises busy. The
// block then computes the cutoff (one squaring per cycle), makes a sum pass
// over the stored values (the exp unit runs only for a value within the
// cutoff) and an output pass (the same steps plus the bit-serial divider and
// the emit). Each result appears for a single cycle with strobe high and
// cannot be stalled; the receiver must take every transfer. busy falls with
// the last result.
module log_likelihood_softmax_normalizer import llsn_pkg::*; #(
	parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input llsn_in_t item,
	output logic strobe,
	output llsn_out_t result
);

	llsn_cmd_t cmd;
	llsn_sts_t sts;

	llsn_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.last_item(item.last_item),
		.sts(sts),
		.cmd(cmd),
		.busy(busy)
	);

	llsn_dp #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.cmd(cmd),
		.sts(sts),
		.strobe(strobe),
		.result(result)
	);

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// tb: self-checking testbench for log_likelihood_softmax_normalizer.
// Depends on llsn_pkg and the block; predicts every probability in fixed point.
module tb;
	import llsn_pkg::*;

	typedef struct packed {
		llsn_in_t payload;
		logic drain;
		logic [6:0] idle_pct;
	} pending_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	llsn_in_t item;
	logic strobe;
	llsn_out_t result;

	pending_t pending_q[$];
	llsn_out_t prob_q[$];
	logic signed [31:0] vec_vals[64];
	int unsigned vec_count;
	logic signed [31:0] vec_max;
	logic vec_dropped;
	logic took;
	int mismatches;
	int idle_pct;

	log_likelihood_softmax_normalizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.strobe(strobe),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned ln_fix(int unsigned n);
		int unsigned k;
		longint unsigned y;
		longint unsigned frac;
		k = 0;
		frac = 0;
		if (n == 0)
			return 0;
		while (k < 31 && (n >> (k + 1)) != 0)
			k++;
		y = (64'(n) << 30) >> k;
		for (int i = 0; i < 16; i++) begin
			y = (y * y) >> 30;
			frac = frac << 1;
			if (y >= 64'h8000_0000) begin
				y = y >> 1;
				frac = frac | 1;
			end
		end
		return (((64'(k) << 16) | frac) * 64'(LN2_Q32)) >> 32;
	endfunction

	function automatic longint unsigned exp_fix(longint unsigned t);
		longint unsigned q;
		longint unsigned r31;
		longint unsigned term;
		longint sum;
		q = t / 64'(LN2_Q16);
		term = 64'(ONE_Q31);
		sum = 64'(ONE_Q31);
		if (q >= 32)
			return 0;
		r31 = (t - q * 64'(LN2_Q16)) << 15;
		for (int k = 1; k <= 12; k++) begin
			term = ((term * r31) >> 31) / k;
			if (k % 2 == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		if (sum > longint'(ONE_Q31))
			sum = longint'(ONE_Q31);
		return longint'(sum) >> q;
	endfunction

	function automatic longint unsigned cutoff(int unsigned n);
		return 64'(LN_1E16_Q) + ln_fix(n);
	endfunction

	task automatic predict_vector();
		longint unsigned cut;
		longint unsigned total;
		longint unsigned t;
		longint unsigned p;
		llsn_out_t r;
		cut = cutoff(vec_count);
		total = 0;
		for (int i = 0; i < vec_count; i++) begin
			t = 64'(longint'(vec_max) - longint'(vec_vals[i]));
			if (t < cut)
				total = total + exp_fix(t);
		end
		total = total & 64'h3F_FFFF_FFFF;
		for (int i = 0; i < vec_count; i++) begin
			t = 64'(longint'(vec_max) - longint'(vec_vals[i]));
			p = 0;
			if (t < cut && total != 0)
				p = (exp_fix(t) << 16) / total;
			r.probability = p[16:0];
			r.item_index = i[5:0];
			r.last_result = (i + 1 == vec_count);
			r.truncated = vec_dropped;
			prob_q = {prob_q, r};
		end
		vec_count = 0;
		vec_max = 32'sh8000_0000;
		vec_dropped = 1'b0;
	endtask

	// result check and transfer-side prediction
	always @(posedge clk) begin
		took = 1'b0;
		if (arst_n) begin
			if (strobe) begin
				if (prob_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %p", result);
				end else begin
					if (result.probability !== prob_q[0].probability ||
					    result.item_index !== prob_q[0].item_index ||
					    result.last_result !== prob_q[0].last_result ||
					    result.truncated !== prob_q[0].truncated) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p got %p", prob_q[0], result);
					end
					void'(prob_q.pop_front());
				end
			end
			if (start && !busy) begin
				took = 1'b1;
				if (vec_count < 64) begin
					vec_vals[vec_count] = item.log_likelihood;
					if (item.log_likelihood > vec_max)
						vec_max = item.log_likelihood;
					vec_count++;
				end else begin
					vec_dropped = 1'b1;
				end
				if (item.last_item)
					predict_vector();
			end
		end
	end

	// driver
	always @(negedge clk) begin
		logic go;
		if (arst_n) begin
			if (took)
				void'(pending_q.pop_front());
			go = 1'b0;
			if (pending_q.size() != 0) begin
				go = 1'b1;
				if (pending_q[0].drain && (prob_q.size() != 0 || busy))
					go = 1'b0;
				else if ($urandom_range(99) < pending_q[0].idle_pct)
					go = 1'b0;
				if (go)
					item <= pending_q[0].payload;
			end
			start <= go;
		end
	end

	task automatic add_item(logic signed [31:0] v, logic last, logic drain = 1'b0);
		pending_t e;
		e.payload.log_likelihood = v;
		e.payload.last_item = last;
		e.drain = drain;
		e.idle_pct = idle_pct[6:0];
		pending_q = {pending_q, e};
	endtask

	task automatic add_vector(int n);
		longint base;
		longint v;
		int mode;
		base = longint'($urandom_range(32'h7FFF_FFFF)) - 64'sh4000_0000;
		mode = $urandom_range(3);
		for (int i = 0; i < n; i++) begin
			if (mode == 0)
				v = longint'(int'($urandom));
			else if (mode == 1)
				v = base - longint'($urandom_range(400000));
			else
				v = base - longint'($urandom_range(3000000));
			add_item(v[31:0], i == n - 1);
		end
	endtask

	initial begin
		longint unsigned c3;
		int made;
		mismatches = 0;
		vec_count = 0;
		vec_max = 32'sh8000_0000;
		vec_dropped = 1'b0;
		took = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		idle_pct = 13;

		add_item(32'sh7FFF_FFFF, 1'b1);
		add_item(32'sh8000_0000, 1'b1);
		add_item(32'sh8000_0000, 1'b0);
		add_item(32'sh7FFF_FFFF, 1'b1);
		add_item(32'sd0, 1'b0);
		add_item(32'sd0, 1'b0);
		add_item(32'sd0, 1'b1);
		c3 = cutoff(3);
		add_item(32'sd0, 1'b0);
		add_item(-32'(c3), 1'b0);
		add_item(-32'(c3 - 1), 1'b1);
		add_item(32'sd1000, 1'b0);
		add_item(32'sd1000 - 32'sd45426 * 31, 1'b0);
		add_item(32'sd1000 - 32'sd45426 * 32, 1'b1);
		add_item(32'sh0001_0000, 1'b0);
		add_item(32'sh0000_8000, 1'b1);

		// full vector, then one dropped item that closes it
		for (int i = 0; i < 64; i++)
			add_item(32'sh0001_0000 - 32'(i * 20000), 1'b0, i == 0);
		add_item(32'sh5555_5555, 1'b1);

		idle_pct = 70;
		made = pending_q.size();
		while (made < 164) begin
			add_vector($urandom_range(1, 9));
			made = pending_q.size();
		end
		idle_pct = 0;
		// overflow with a dropped last element
		for (int i = 0; i < 66; i++)
			add_item(32'($urandom), i == 65, i == 0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (pending_q.size() == 0 && prob_q.size() == 0 && !busy);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && prob_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

### log_likelihood_softmax_normalizer.f
rtl/llsn_pkg.sv
rtl/llsn_ram.sv
rtl/llsn_exp.sv
rtl/llsn_dp.sv
rtl/llsn_ctrl.sv
rtl/log_likelihood_softmax_normalizer.sv
tb/sv/tb.sv
